@@ src/packed_pixel_unpack_descramble_defines.svh @@
// assertion macros used by the checker file
`ifndef PACKED_PIXEL_UNPACK_DESCRAMBLE_DEFINES_SVH
`define PACKED_PIXEL_UNPACK_DESCRAMBLE_DEFINES_SVH

// property checked at every clock edge, reset included
`define PPUD_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

// property checked only while out of reset
`define PPUD_ASSERT_RUN(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

`endif

@@ src/ppud_pkg.sv @@
// shared types, constants and functions of the packed pixel unpacker
package ppud_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int QDEPTH     = 4;

  typedef logic [12:0] size_t;
  typedef logic [11:0] coord_t;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_UNPACK_ENABLE   = 2'd2;
  localparam logic [1:0] REG_DESCRAMBLE_MODE = 2'd3;

  // descramble layouts
  localparam logic [2:0] MODE_IDENTITY  = 3'd0;
  localparam logic [2:0] MODE_TD_BU     = 3'd1;
  localparam logic [2:0] MODE_CENTER_OUT = 3'd2;
  localparam logic [2:0] MODE_CU_BU     = 3'd3;
  localparam logic [2:0] MODE_TD_CD     = 3'd4;

  typedef struct packed {
    size_t      image_width;
    size_t      image_height;
    logic       unpack_enable;
    logic [2:0] descramble_mode;
  } cfg_t;

  // one pixel between front and back, row still in input order
  typedef struct packed {
    logic [15:0] val;
    logic        expand;
    coord_t      row;
    coord_t      col;
    logic        run_end;
    logic        frame_end;
  } pix_entry_t;

  // one finished result
  typedef struct packed {
    logic [15:0] pixel_value;
    coord_t      dest_row;
    coord_t      dest_col;
    logic        run_end;
    logic        frame_end;
  } out_entry_t;

  // push strobes from front to queue
  typedef struct packed {
    logic first;
    logic second;
  } push_ctl_t;

  // clamp a size register to 1..limit
  function automatic size_t clamp_size(input size_t v, input size_t limit);
    size_t r;
    r = v;
    if (v == size_t'(0)) r = size_t'(1);
    else if (v > limit) r = limit;
    return r;
  endfunction

  // input row to output row for the descramble layouts
  function automatic coord_t map_row(input coord_t r, input size_t h, input logic [2:0] mode);
    size_t r13;
    size_t half;
    size_t y;
    size_t res;
    logic  odd;
    r13  = {1'b0, r};
    half = h >> 1;
    y    = {2'b00, r[11:1]};
    odd  = r[0];
    res  = r13;
    if (r13 >= h || mode == MODE_IDENTITY || mode > MODE_TD_CD) begin
      res = r13;
    end else if (h[0] && r13 == h - size_t'(1)) begin
      res = r13;
    end else begin
      case (mode)
        MODE_TD_BU:      res = odd ? (h - size_t'(1) - y) : y;
        MODE_CENTER_OUT: res = odd ? (half + y) : (half - size_t'(1) - y);
        MODE_CU_BU:      res = odd ? (h - size_t'(1) - y) : (half - size_t'(1) - y);
        default:         res = odd ? (half + y) : y;
      endcase
    end
    return res[11:0];
  endfunction

endpackage

@@ src/ppud_front.sv @@
// front end: word unpacking, column and row counting
module ppud_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ppud_pkg::cfg_t         cfg,
  input  logic                   accept,
  input  logic [15:0]            data_word,
  output ppud_pkg::push_ctl_t    push,
  output ppud_pkg::pix_entry_t   entry0,
  output ppud_pkg::pix_entry_t   entry1
);

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       carry_r, carry_nxt;
  ppud_pkg::coord_t col_r, col_nxt;
  ppud_pkg::coord_t row_r, row_nxt;

  ppud_pkg::size_t  wc, hc;
  logic [15:0]      val0, val1;
  logic             want_second, second;
  logic             rd0, fd0, rd1, fd1;
  ppud_pkg::coord_t c1, r1, c2, r2;

  assign wc = ppud_pkg::clamp_size(cfg.image_width, ppud_pkg::size_t'(ppud_pkg::MAX_WIDTH));
  assign hc = ppud_pkg::clamp_size(cfg.image_height, ppud_pkg::size_t'(ppud_pkg::MAX_HEIGHT));

  // split the word into codes by group phase
  always_comb begin
    val0        = data_word;
    val1        = {4'h0, data_word[11:0]};
    want_second = 1'b0;
    phase_nxt   = 2'd0;
    carry_nxt   = 8'h00;
    if (cfg.unpack_enable) begin
      case (phase_r)
        2'd0: begin
          val0      = {4'h0, data_word[15:4]};
          carry_nxt = {4'h0, data_word[3:0]};
          phase_nxt = 2'd1;
        end
        2'd1: begin
          val0      = {4'h0, carry_r[3:0], data_word[15:8]};
          carry_nxt = data_word[7:0];
          phase_nxt = 2'd2;
        end
        default: begin
          val0        = {4'h0, carry_r, data_word[15:12]};
          want_second = 1'b1;
        end
      endcase
    end
  end

  // position of the first pixel and the step after it
  always_comb begin
    rd0 = ({1'b0, col_r} + ppud_pkg::size_t'(1)) >= wc;
    fd0 = rd0 && (({1'b0, row_r} + ppud_pkg::size_t'(1)) >= hc);
    c1  = rd0 ? '0 : col_r + ppud_pkg::coord_t'(1);
    r1  = fd0 ? '0 : (rd0 ? row_r + ppud_pkg::coord_t'(1) : row_r);
    second = want_second && !fd0;
    rd1 = ({1'b0, c1} + ppud_pkg::size_t'(1)) >= wc;
    fd1 = rd1 && (({1'b0, r1} + ppud_pkg::size_t'(1)) >= hc);
    c2  = rd1 ? '0 : c1 + ppud_pkg::coord_t'(1);
    r2  = fd1 ? '0 : (rd1 ? r1 + ppud_pkg::coord_t'(1) : r1);
    col_nxt = second ? c2 : c1;
    row_nxt = second ? r2 : r1;
  end

  // entries toward the queue
  always_comb begin
    entry0.val       = val0;
    entry0.expand    = cfg.unpack_enable;
    entry0.row       = row_r;
    entry0.col       = col_r;
    entry0.run_end   = !second;
    entry0.frame_end = fd0;
    entry1.val       = val1;
    entry1.expand    = cfg.unpack_enable;
    entry1.row       = r1;
    entry1.col       = c1;
    entry1.run_end   = 1'b1;
    entry1.frame_end = fd1;
    push.first       = accept;
    push.second      = accept && second;
  end

  // group and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      carry_r <= 8'h00;
      col_r   <= '0;
      row_r   <= '0;
    end else if (accept) begin
      if ((second && fd1) || (!second && fd0)) begin
        phase_r <= 2'd0;
        carry_r <= 8'h00;
      end else begin
        phase_r <= phase_nxt;
        carry_r <= carry_nxt;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ src/ppud_queue.sv @@
// short pixel queue between front and back, two pushes and one pop a cycle
module ppud_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ppud_pkg::push_ctl_t    push,
  input  ppud_pkg::pix_entry_t   entry0,
  input  ppud_pkg::pix_entry_t   entry1,
  output logic                   full,
  output logic                   nempty,
  input  logic                   pop,
  output ppud_pkg::pix_entry_t   head
);

  localparam int AW = $clog2(ppud_pkg::QDEPTH);

  ppud_pkg::pix_entry_t mem_r [ppud_pkg::QDEPTH];
  logic [AW-1:0]        wp_r, rp_r;
  logic [AW:0]          cnt_r;
  logic [AW:0]          n_in;
  logic [AW-1:0]        wp1;

  assign wp1    = wp_r + AW'(1);
  assign n_in   = (AW+1)'(push.first) + (AW+1)'(push.second);
  assign full   = cnt_r > (AW+1)'(ppud_pkg::QDEPTH - 2);
  assign nempty = cnt_r != '0;
  assign head   = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.first) mem_r[wp_r] <= entry0;
    if (push.second) mem_r[wp1] <= entry1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_in[AW-1:0];
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + n_in - (AW+1)'(pop);
    end
  end

endmodule

@@ src/ppud_back.sv @@
// back end: square expansion, row descramble and output buffer
module ppud_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ppud_pkg::cfg_t         cfg,
  input  logic                   q_nempty,
  input  ppud_pkg::pix_entry_t   q_head,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output ppud_pkg::out_entry_t   out_word
);

  ppud_pkg::size_t      hc;
  logic [11:0]          code;
  logic [23:0]          sq;
  ppud_pkg::out_entry_t p_nxt, p_r;
  logic                 p_v_r;
  logic                 p_move, of_space, pop_acc;

  ppud_pkg::out_entry_t of_mem_r [2];
  logic                 of_wp_r, of_rp_r;
  logic [1:0]           of_cnt_r;

  assign hc = ppud_pkg::clamp_size(cfg.image_height, ppud_pkg::size_t'(ppud_pkg::MAX_HEIGHT));

  // handshake between stage and output buffer
  assign pop_acc  = out_pop && !out_empty;
  assign of_space = (of_cnt_r != 2'd2) || pop_acc;
  assign p_move   = p_v_r && of_space;
  assign q_pop    = q_nempty && (!p_v_r || p_move);

  // expansion and row mapping of the queue head
  always_comb begin
    code = q_head.val[11:0];
    sq   = {12'h000, code} * {12'h000, code};
    p_nxt.pixel_value = q_head.val;
    if (q_head.expand) begin
      p_nxt.pixel_value = (code > 12'd256) ? sq[23:8] : {4'h0, code};
    end
    p_nxt.dest_row  = ppud_pkg::map_row(q_head.row, hc, cfg.descramble_mode);
    p_nxt.dest_col  = q_head.col;
    p_nxt.run_end   = q_head.run_end;
    p_nxt.frame_end = q_head.frame_end;
  end

  // result stage
  always_ff @(posedge clk) begin
    if (q_pop) p_r <= p_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (q_pop) begin
      p_v_r <= 1'b1;
    end else if (p_move) begin
      p_v_r <= 1'b0;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (p_move) of_mem_r[of_wp_r] <= p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wp_r  <= 1'b0;
      of_rp_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      if (p_move) of_wp_r <= !of_wp_r;
      if (pop_acc) of_rp_r <= !of_rp_r;
      of_cnt_r <= of_cnt_r + 2'(p_move) - 2'(pop_acc);
    end
  end

  assign out_empty = of_cnt_r == 2'd0;
  assign out_word  = of_mem_r[of_rp_r];

endmodule

@@ src/packed_pixel_unpack_descramble.sv @@
// top level of the packed pixel unpacker with row descramble
//
// Input is a queue-style channel: a 16-bit camera word is taken at an edge
// with in_push high and in_full low. With unpacking on, three words carry four
// 12-bit codes; codes above 256 are expanded as code*code>>8. With unpacking
// off each word is one pixel. Results leave on a queue-style channel: while
// out_empty is low the oldest pixel is on the out_ ports with its output row
// and column, and out_pop takes it. run_end marks the last pixel of a word,
// frame_end the last pixel of the frame.
// Pixels reach the result ports through the queue, result stage and buffer.
// Throughput: one word per cycle in unless in_full is high, one pixel per
// cycle out, paced by the result port, which also paces the input when unpacked.
// A four-entry pixel queue sits between the unpacker and the expander; in_full
// rises when it cannot take two more pixels, so a stalled receiver backs up
// through the output buffer and queue into the input side without loss.
// Reset clears the counters, queue and buffer and loads the size defaults
// 2560 x 2160, unpacking on, descramble layout 1. Write cfg_ only when idle.
module packed_pixel_unpack_descramble (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_data_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_pixel_value,
  output logic [11:0] out_dest_row,
  output logic [11:0] out_dest_col,
  output logic        out_run_end,
  output logic        out_frame_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  ppud_pkg::cfg_t       cfg_r;
  ppud_pkg::push_ctl_t  push;
  ppud_pkg::pix_entry_t entry0, entry1, q_head;
  ppud_pkg::out_entry_t out_word;
  logic                 q_full, q_nempty, q_pop, accept;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= ppud_pkg::size_t'(2560);
      cfg_r.image_height    <= ppud_pkg::size_t'(2160);
      cfg_r.unpack_enable   <= 1'b1;
      cfg_r.descramble_mode <= ppud_pkg::MODE_TD_BU;
    end else if (cfg_we) begin
      case (cfg_index)
        ppud_pkg::REG_IMAGE_WIDTH:     cfg_r.image_width     <= cfg_data;
        ppud_pkg::REG_IMAGE_HEIGHT:    cfg_r.image_height    <= cfg_data;
        ppud_pkg::REG_UNPACK_ENABLE:   cfg_r.unpack_enable   <= cfg_data[0];
        ppud_pkg::REG_DESCRAMBLE_MODE: cfg_r.descramble_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ppud_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .data_word (in_data_word),
    .push      (push),
    .entry0    (entry0),
    .entry1    (entry1)
  );

  ppud_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .entry0 (entry0),
    .entry1 (entry1),
    .full   (q_full),
    .nempty (q_nempty),
    .pop    (q_pop),
    .head   (q_head)
  );

  ppud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  assign out_pixel_value = out_word.pixel_value;
  assign out_dest_row    = out_word.dest_row;
  assign out_dest_col    = out_word.dest_col;
  assign out_run_end     = out_word.run_end;
  assign out_frame_end   = out_word.frame_end;

endmodule

@@ src/ppud_checker.sv @@
// port-level checker for the packed pixel unpacker, bound to the top level
`include "packed_pixel_unpack_descramble_defines.svh"

module ppud_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_pixel_value,
  input logic        out_run_end,
  input logic        out_frame_end
);

  // reset leaves no result waiting
  `PPUD_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> out_empty, "result after reset")

  // reset leaves the input side open
  `PPUD_ASSERT_ALWAYS(a_reset_open, clk, $past(!rst_n) |-> !in_full, "input full after reset")

  // the last pixel of a frame always closes its word
  `PPUD_ASSERT_RUN(a_frame_run, clk, rst_n, (!out_empty && out_frame_end) |-> out_run_end,
    "frame end without run end")

  // a waiting word stays until popped
  `PPUD_ASSERT_RUN(a_hold, clk, rst_n,
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_pixel_value)),
    "waiting word changed")

endmodule

bind packed_pixel_unpack_descramble ppud_checker u_ppud_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_pixel_value (out_pixel_value),
  .out_run_end     (out_run_end),
  .out_frame_end   (out_frame_end)
);

@@ sim/packed_pixel_unpack_descramble_tb.sv @@
// testbench for the packed pixel unpacker: directed table plus random words, checked by a predictor
`timescale 1ns / 1ps

module packed_pixel_unpack_descramble_tb;

  localparam int ITEM_COUNT  = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_PAD   = 16;

  typedef enum logic {ROW_WORD, ROW_SETUP} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t            kind;
    logic [15:0]          word;
    ppud_pkg::cfg_t       setup;
    bit                   typed;
    ppud_pkg::out_entry_t pix;
  } stim_row_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic        in_full;
  logic [15:0] in_data_word = '0;
  logic        out_empty;
  logic        out_pop      = 1'b0;
  logic [15:0] out_pixel_value;
  logic [11:0] out_dest_row;
  logic [11:0] out_dest_col;
  logic        out_run_end;
  logic        out_frame_end;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = ppud_pkg::REG_IMAGE_WIDTH;
  logic [12:0] cfg_data     = '0;

  packed_pixel_unpack_descramble u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_word    (in_data_word),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_value (out_pixel_value),
    .out_dest_row    (out_dest_row),
    .out_dest_col    (out_dest_col),
    .out_run_end     (out_run_end),
    .out_frame_end   (out_frame_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predictor state and the pixels still owed by the block
  ppud_pkg::cfg_t       active_cfg;
  logic [1:0]           grp_phase;
  logic [7:0]           carry_bits;
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  ppud_pkg::out_entry_t pending_pixels[$];
  ppud_pkg::out_entry_t want;

  int        mismatch_count = 0;
  int        words_taken    = 0;
  int        burst_left     = 0;
  int        quiet_cycles   = 0;
  bit        hold_request   = 1'b0;
  bit        hold_done      = 1'b0;
  int        hold_left      = 0;
  bit [31:0] stall_bits     = '1;
  int        stall_age      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // size register as the block uses it
  function automatic int unsigned bounded_size(input ppud_pkg::size_t v,
                                               input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // undo the camera's square-root table for codes above 256
  function automatic logic [15:0] square_expand(input logic [11:0] c);
    logic [23:0] sq;
    sq = {12'd0, c} * {12'd0, c};
    return (c > 12'd256) ? sq[23:8] : {4'd0, c};
  endfunction

  function automatic ppud_pkg::cfg_t make_setup(input ppud_pkg::size_t wd,
                                                input ppud_pkg::size_t ht, input logic unp,
                                                input logic [2:0] mode);
    ppud_pkg::cfg_t c;
    c.image_width     = wd;
    c.image_height    = ht;
    c.unpack_enable   = unp;
    c.descramble_mode = mode;
    return c;
  endfunction

  function automatic stim_row_t setup_row(input ppud_pkg::size_t wd, input ppud_pkg::size_t ht,
                                          input logic unp, input logic [2:0] mode);
    stim_row_t r;
    r.kind  = ROW_SETUP;
    r.word  = '0;
    r.setup = make_setup(wd, ht, unp, mode);
    r.typed = 1'b0;
    r.pix   = '0;
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic [15:0] w);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.word  = w;
    r.setup = '0;
    r.typed = 1'b0;
    r.pix   = '0;
    return r;
  endfunction

  // word with a single pixel whose value and place are known by hand
  function automatic stim_row_t typed_row(input logic [15:0] w, input logic [15:0] val,
                                          input ppud_pkg::coord_t row,
                                          input ppud_pkg::coord_t col,
                                          input logic fend);
    stim_row_t r;
    r = word_row(w);
    r.typed             = 1'b1;
    r.pix.pixel_value   = val;
    r.pix.dest_row      = row;
    r.pix.dest_col      = col;
    r.pix.run_end       = 1'b1;
    r.pix.frame_end     = fend;
    return r;
  endfunction

  function automatic ppud_pkg::size_t random_size(input int unsigned typical);
    case ($urandom_range(0, 9))
      0:       return ppud_pkg::size_t'(0);
      1:       return ppud_pkg::size_t'(ppud_pkg::MAX_WIDTH);
      2:       return '1;
      3:       return ppud_pkg::size_t'($urandom_range(13, 8191));
      default: return ppud_pkg::size_t'($urandom_range(1, typical));
    endcase
  endfunction

  // place one pixel in the output frame and move the column and row on
  task automatic place_pixel(input logic [15:0] value, output bit frame_done);
    int unsigned          w;
    int unsigned          h;
    int unsigned          half;
    int unsigned          y;
    int unsigned          dest;
    bit                   row_done;
    ppud_pkg::out_entry_t pix;
    w        = bounded_size(active_cfg.image_width, ppud_pkg::MAX_WIDTH);
    h        = bounded_size(active_cfg.image_height, ppud_pkg::MAX_HEIGHT);
    row_done   = col_cnt + 1 >= w;
    frame_done = row_done && (row_cnt + 1 >= h);

    // descramble: rows pair up and split between two halves of the frame
    half = h / 2;
    y    = row_cnt / 2;
    dest = row_cnt;
    if (row_cnt < h && !(h[0] && row_cnt == h - 1)) begin
      case (active_cfg.descramble_mode)
        ppud_pkg::MODE_TD_BU:      dest = row_cnt[0] ? h - 1 - y : y;
        ppud_pkg::MODE_CENTER_OUT: dest = row_cnt[0] ? half + y : half - 1 - y;
        ppud_pkg::MODE_CU_BU:      dest = row_cnt[0] ? h - 1 - y : half - 1 - y;
        ppud_pkg::MODE_TD_CD:      dest = row_cnt[0] ? half + y : y;
        default:                   dest = row_cnt;
      endcase
    end

    pix.pixel_value = value;
    pix.dest_row    = dest[11:0];
    pix.dest_col    = col_cnt[11:0];
    pix.run_end     = 1'b0;
    pix.frame_end   = frame_done;
    pending_pixels.push_back(pix);

    if (frame_done) begin
      col_cnt    = 0;
      row_cnt    = 0;
      grp_phase  = 2'd0;
      carry_bits = '0;
    end else if (row_done) begin
      col_cnt = 0;
      row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // pixels carried by one camera word
  task automatic unpack_word_pixels(input logic [15:0] w);
    logic [11:0] code;
    bit          frame_done;
    if (!active_cfg.unpack_enable) begin
      grp_phase  = 2'd0;
      carry_bits = '0;
      place_pixel(w, frame_done);
    end else begin
      case (grp_phase)
        2'd0: begin
          code       = w[15:4];
          carry_bits = {4'd0, w[3:0]};
          grp_phase  = 2'd1;
          place_pixel(square_expand(code), frame_done);
        end
        2'd1: begin
          code       = {carry_bits[3:0], w[15:8]};
          carry_bits = w[7:0];
          grp_phase  = 2'd2;
          place_pixel(square_expand(code), frame_done);
        end
        default: begin
          // second code is lost when the first one closes the frame
          code       = {carry_bits, w[15:12]};
          grp_phase  = 2'd0;
          carry_bits = '0;
          place_pixel(square_expand(code), frame_done);
          if (!frame_done) place_pixel(square_expand(w[11:0]), frame_done);
        end
      endcase
    end
    pending_pixels[pending_pixels.size() - 1].run_end = 1'b1;
  endtask

  // hold a word on the input until the block takes it
  task automatic offer_word(input stim_row_t row);
    in_push      <= 1'b1;
    in_data_word <= row.word;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_taken++;
    unpack_word_pixels(row.word);
    if (row.typed) pending_pixels[pending_pixels.size() - 1] = row.pix;
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every owed pixel has come out
  task automatic settle();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // all four registers on consecutive edges, block idle
  task automatic write_setup(input ppud_pkg::cfg_t s);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      case (2'(i))
        ppud_pkg::REG_IMAGE_WIDTH:   cfg_data <= s.image_width;
        ppud_pkg::REG_IMAGE_HEIGHT:  cfg_data <= s.image_height;
        ppud_pkg::REG_UNPACK_ENABLE: cfg_data <= {12'd0, s.unpack_enable};
        default:                     cfg_data <= {10'd0, s.descramble_mode};
      endcase
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    active_cfg = s;
  endtask

  task automatic check_field(input string name, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (actual !== expected) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, expected, actual);
    end
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_pop   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_age = 32;
        case ($urandom_range(0, 3))
          0:       stall_bits = '1;
          1:       stall_bits = $urandom | $urandom;
          default: stall_bits = $urandom;
        endcase
      end
      out_pop    <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[31:1]};
      stall_age--;
    end
  end

  // compare each popped word with the oldest owed pixel
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: pixel expected none got value %h row %0d col %0d", $time,
                 out_pixel_value, out_dest_row, out_dest_col);
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_value", want.pixel_value, out_pixel_value);
        check_field("dest_row", {4'd0, want.dest_row}, {4'd0, out_dest_row});
        check_field("dest_col", {4'd0, want.dest_col}, {4'd0, out_dest_col});
        check_field("run_end", {15'd0, want.run_end}, {15'd0, out_run_end});
        check_field("frame_end", {15'd0, want.frame_end}, {15'd0, out_frame_end});
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t      dir_rows[$];
    ppud_pkg::cfg_t setup;
    logic [15:0]    w;
    int             target;
    int             phase_idx;
    int             phase_len;

    // reset defaults of the block
    active_cfg = make_setup(ppud_pkg::size_t'(2560), ppud_pkg::size_t'(2160), 1'b1,
                            ppud_pkg::MODE_TD_BU);
    grp_phase  = 2'd0;
    carry_bits = '0;
    col_cnt    = 0;
    row_cnt    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: code boundary at 256, largest code, full group
    dir_rows.push_back(typed_row(16'h1000, 16'd256, 12'd0, 12'd0, 1'b0));
    dir_rows.push_back(typed_row(16'h1100, 16'd17, 12'd0, 12'd1, 1'b0));
    dir_rows.push_back(word_row(16'h0101));
    dir_rows.push_back(typed_row(16'hffff, 16'd65504, 12'd0, 12'd4, 1'b0));
    dir_rows.push_back(typed_row(16'h0000, 16'd57600, 12'd0, 12'd5, 1'b0));
    dir_rows.push_back(word_row(16'hffff));
    // zero sizes clamp to one pixel, raw words, column left beyond the width
    dir_rows.push_back(setup_row(ppud_pkg::size_t'(0), ppud_pkg::size_t'(0), 1'b0,
                                 ppud_pkg::MODE_IDENTITY));
    dir_rows.push_back(typed_row(16'hffff, 16'hffff, 12'd0, 12'd8, 1'b1));
    dir_rows.push_back(typed_row(16'h0000, 16'h0000, 12'd0, 12'd0, 1'b1));
    dir_rows.push_back(typed_row(16'h8000, 16'h8000, 12'd0, 12'd0, 1'b1));
    dir_rows.push_back(typed_row(16'h0001, 16'h0001, 12'd0, 12'd0, 1'b1));
    dir_rows.push_back(word_row(16'h5a5a));
    // width not a multiple of four: frame closes on the first code of a group end
    dir_rows.push_back(setup_row(ppud_pkg::size_t'(7), ppud_pkg::size_t'(1), 1'b1,
                                 ppud_pkg::MODE_TD_CD));
    dir_rows.push_back(typed_row(16'h1010, 16'd258, 12'd0, 12'd0, 1'b0));
    dir_rows.push_back(word_row(16'habcd));
    dir_rows.push_back(word_row(16'h0f0f));
    dir_rows.push_back(word_row(16'h8001));
    dir_rows.push_back(word_row(16'h7ffe));
    dir_rows.push_back(word_row(16'hc3a5));
    dir_rows.push_back(word_row(16'h0000));
    dir_rows.push_back(word_row(16'hffff));
    // width shrunk mid-frame, four rows top-down/bottom-up
    dir_rows.push_back(setup_row(ppud_pkg::size_t'(2), ppud_pkg::size_t'(4), 1'b1,
                                 ppud_pkg::MODE_TD_BU));
    dir_rows.push_back(word_row(16'h1234));
    dir_rows.push_back(word_row(16'h5678));
    dir_rows.push_back(word_row(16'h9abc));
    dir_rows.push_back(word_row(16'hdef0));
    dir_rows.push_back(word_row(16'h0ff0));
    dir_rows.push_back(word_row(16'hf00f));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SETUP) begin
        settle();
        write_setup(dir_rows[i].setup);
      end else begin
        offer_word(dir_rows[i]);
        pace_sender();
      end
    end

    // random phases, each with its own register setting
    target    = words_taken + ITEM_COUNT;
    phase_idx = 0;
    while (words_taken < target) begin
      settle();
      case (phase_idx)
        0: setup = make_setup('1, ppud_pkg::size_t'(ppud_pkg::MAX_HEIGHT), 1'b1,
                              ppud_pkg::MODE_CENTER_OUT);
        1: setup = make_setup(ppud_pkg::size_t'(4), ppud_pkg::size_t'(2), 1'b1,
                              ppud_pkg::MODE_CU_BU);
        2: setup = make_setup(ppud_pkg::size_t'(ppud_pkg::MAX_WIDTH), '1, 1'b0,
                              ppud_pkg::MODE_TD_BU);
        default: setup = make_setup(random_size(12), random_size(7),
                                    $urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)));
      endcase
      write_setup(setup);
      // long receiver hold-off while this phase keeps pushing
      if (phase_idx == 1) hold_request = 1'b1;
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0:       w = 16'h0000;
          1:       w = 16'hffff;
          2:       w = {12'($urandom_range(255, 257)), 4'($urandom)};
          default: w = 16'($urandom);
        endcase
        offer_word(word_row(w));
        pace_sender();
      end
      phase_idx++;
    end

    settle();
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ packed_pixel_unpack_descramble.f @@
+incdir+src
src/ppud_pkg.sv
src/ppud_front.sv
src/ppud_queue.sv
src/ppud_back.sv
src/packed_pixel_unpack_descramble.sv
src/ppud_checker.sv
sim/packed_pixel_unpack_descramble_tb.sv
